/* design/thcs_pkg.sv */
// thcs_pkg: word types, colour ramp rom and shared constants for the terrain
// height colour shader; used by every module of the block, depends on nothing
`timescale 1ns / 1ps

package thcs_pkg;

	// field widths fixed by the pixel format
	localparam int HEIGHT_W   = 16;
	localparam int CH_W       = 8;
	localparam int RAMP_MAX   = 16;
	localparam int RAMP_IDX_W = 4;

	// ramp geometry: every land segment is one fixed span wide
	localparam int SEG_SPAN   = 250;
	localparam int FULL_SCALE = 255;
	// d * 255 / 250 equals d + d / 50 for whole d
	localparam int FRAC_STEP  = SEG_SPAN / (FULL_SCALE - SEG_SPAN);
	localparam int FRAC_STEPS = (SEG_SPAN - 1) / FRAC_STEP;

	// fixed water colour
	localparam logic [CH_W-1:0] WATER_R = 8'd64;
	localparam logic [CH_W-1:0] WATER_G = 8'd96;
	localparam logic [CH_W-1:0] WATER_B = 8'd240;

	// input word
	typedef struct packed {
		logic signed [HEIGHT_W-1:0] height;
		logic [CH_W-1:0]            illumination;
		logic                       frame_end;
	} pixel_t;

	// output word
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            frame_last;
	} colour_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} rgb_t;

	// side information that rides along the pipe
	typedef struct packed {
		logic            water;
		logic [CH_W-1:0] illumination;
		logic            frame_end;
	} side_t;

	// located segment: offset into it and its two end colours
	typedef struct packed {
		logic [CH_W-1:0] offset;
		rgb_t            lo;
		rgb_t            hi;
		logic            clamp;
		side_t           side;
	} seg_t;

	// ramp colour before shading
	typedef struct packed {
		rgb_t  c;
		side_t side;
	} tint_t;

	// ramp heights in metres
	function automatic logic signed [HEIGHT_W-1:0] ramp_height(
		input logic [RAMP_IDX_W-1:0] idx
	);
		logic signed [HEIGHT_W-1:0] h;
		case (idx)
			4'd0:    h = -16'sd1;
			4'd1:    h = 16'sd0;
			4'd2:    h = 16'sd250;
			4'd3:    h = 16'sd500;
			4'd4:    h = 16'sd750;
			4'd5:    h = 16'sd1000;
			4'd6:    h = 16'sd1250;
			4'd7:    h = 16'sd1500;
			4'd8:    h = 16'sd1750;
			4'd9:    h = 16'sd2000;
			4'd10:   h = 16'sd2250;
			4'd11:   h = 16'sd2500;
			4'd12:   h = 16'sd2750;
			4'd13:   h = 16'sd3000;
			4'd14:   h = 16'sd3250;
			4'd15:   h = 16'sd3500;
			default: h = 16'sd3500;
		endcase
		return h;
	endfunction

	// ramp colours, entries past the snow line repeat the top colour
	function automatic rgb_t ramp_colour(input logic [RAMP_IDX_W-1:0] idx);
		rgb_t c;
		case (idx)
			4'd0:    c = '{8'hff, 8'hff, 8'hff};
			4'd1:    c = '{8'h70, 8'hc0, 8'ha7};
			4'd2:    c = '{8'hca, 8'he7, 8'hb9};
			4'd3:    c = '{8'hf4, 8'hea, 8'haf};
			4'd4:    c = '{8'hdc, 8'hb2, 8'h82};
			4'd5:    c = '{8'hca, 8'h8e, 8'h72};
			4'd6:    c = '{8'hde, 8'hc8, 8'hbd};
			4'd7:    c = '{8'he3, 8'he4, 8'he9};
			4'd8:    c = '{8'hdb, 8'hd9, 8'hef};
			4'd9:    c = '{8'hce, 8'hcd, 8'hf5};
			4'd10:   c = '{8'hc2, 8'hc1, 8'hfa};
			default: c = '{8'hb7, 8'hb9, 8'hff};
		endcase
		return c;
	endfunction

	// (f * hi + (255 - f) * lo) >> 8 for one channel
	function automatic logic [CH_W-1:0] blend_ch(
		input logic [CH_W-1:0] f,
		input logic [CH_W-1:0] lo,
		input logic [CH_W-1:0] hi
	);
		logic [2*CH_W-1:0] sum;
		sum = 16'(f) * 16'(hi) + 16'(CH_W'(FULL_SCALE) - f) * 16'(lo);
		return sum[2*CH_W-1:CH_W];
	endfunction

endpackage

/* design/thcs_locate.sv */
// thcs_locate: first two pipe stages, ramp compare lanes then segment select
// depends on thcs_pkg for the ramp rom and word types
`timescale 1ns / 1ps

module thcs_locate #(
	parameter int RAMP_ENTRIES = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vin,
	input  logic [1:0]            en,
	input  thcs_pkg::pixel_t      pixel,
	output logic [1:0]            v,
	output thcs_pkg::seg_t        seg
);

	localparam int RW    = thcs_pkg::RAMP_IDX_W;
	localparam int IDX_W = $clog2(RAMP_ENTRIES);

	logic [RAMP_ENTRIES-1:0]            geq;
	logic [RAMP_ENTRIES-1:0]            geq_s1;
	logic signed [thcs_pkg::HEIGHT_W-1:0] height_s1;
	thcs_pkg::side_t                    side_s1;
	logic [IDX_W-1:0]                   idx_lo;
	logic [IDX_W-1:0]                   idx_hi;
	logic                               clamp;
	logic [thcs_pkg::HEIGHT_W-1:0]      dist_full;
	thcs_pkg::seg_t                     seg_d;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[0]) begin
				v[0] <= vin;
			end
			if (en[1]) begin
				v[1] <= v[0];
			end
		end
	end

	// one compare lane per ramp entry
	always_comb begin
		for (int k = 0; k < RAMP_ENTRIES; k++) begin
			geq[k] = pixel.height >= thcs_pkg::ramp_height(RW'(k));
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			geq_s1                 <= geq;
			height_s1              <= pixel.height;
			side_s1.water          <= pixel.height[thcs_pkg::HEIGHT_W-1] ||
			                          (pixel.height == '0);
			side_s1.illumination   <= pixel.illumination;
			side_s1.frame_end      <= pixel.frame_end;
		end
	end

	// highest entry not above the height; heights rise so geq is a thermometer
	always_comb begin
		idx_lo = '0;
		for (int k = 0; k < RAMP_ENTRIES - 1; k++) begin
			if (geq_s1[k]) begin
				idx_lo = IDX_W'(k);
			end
		end
		idx_hi    = idx_lo + 1'b1;
		clamp     = geq_s1[RAMP_ENTRIES-1];
		dist_full = height_s1 - thcs_pkg::ramp_height(RW'(idx_lo));

		seg_d.offset = dist_full[thcs_pkg::CH_W-1:0];
		seg_d.clamp  = clamp;
		seg_d.side   = side_s1;
		seg_d.hi     = thcs_pkg::ramp_colour(RW'(idx_hi));
		if (clamp) begin
			seg_d.lo = thcs_pkg::ramp_colour(RW'(RAMP_ENTRIES - 1));
		end else begin
			seg_d.lo = thcs_pkg::ramp_colour(RW'(idx_lo));
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			seg <= seg_d;
		end
	end

endmodule

/* design/thcs_blend.sv */
// thcs_blend: stages three and four, blend fraction then channel interpolation
// depends on thcs_pkg for word types and the blend function
`timescale 1ns / 1ps

module thcs_blend (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vin,
	input  logic [1:0]      en,
	input  thcs_pkg::seg_t  seg,
	output logic [1:0]      v,
	output thcs_pkg::tint_t tint
);

	localparam int CW = thcs_pkg::CH_W;

	logic [CW-1:0]   steps;
	logic [CW-1:0]   frac_s3;
	thcs_pkg::seg_t  seg_s3;
	thcs_pkg::tint_t tint_d;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[0]) begin
				v[0] <= vin;
			end
			if (en[1]) begin
				v[1] <= v[0];
			end
		end
	end

	// fraction d * 255 / span as d plus a few threshold steps
	always_comb begin
		steps = '0;
		for (int k = 1; k <= thcs_pkg::FRAC_STEPS; k++) begin
			if (seg.offset >= CW'(k * thcs_pkg::FRAC_STEP)) begin
				steps = steps + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			frac_s3 <= seg.offset + steps;
			seg_s3  <= seg;
		end
	end

	// interpolate each channel, exact top colour when clamped
	always_comb begin
		tint_d.side = seg_s3.side;
		if (seg_s3.clamp) begin
			tint_d.c = seg_s3.lo;
		end else begin
			tint_d.c.r = thcs_pkg::blend_ch(frac_s3, seg_s3.lo.r, seg_s3.hi.r);
			tint_d.c.g = thcs_pkg::blend_ch(frac_s3, seg_s3.lo.g, seg_s3.hi.g);
			tint_d.c.b = thcs_pkg::blend_ch(frac_s3, seg_s3.lo.b, seg_s3.hi.b);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			tint <= tint_d;
		end
	end

endmodule

/* design/thcs_shade.sv */
// thcs_shade: last stage, illumination scaling and water override into the
// output register; depends on thcs_pkg for word types and water colour
`timescale 1ns / 1ps

module thcs_shade (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vin,
	input  logic              en,
	input  thcs_pkg::tint_t   tint,
	output logic              v,
	output thcs_pkg::colour_t colour
);

	localparam int CW = thcs_pkg::CH_W;

	logic [2*CW-1:0]   prod_r;
	logic [2*CW-1:0]   prod_g;
	logic [2*CW-1:0]   prod_b;
	thcs_pkg::colour_t colour_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= 1'b0;
		end else if (en) begin
			v <= vin;
		end
	end

	// scale by illumination / 256, water stays unshaded
	always_comb begin
		prod_r = 16'(tint.c.r) * 16'(tint.side.illumination);
		prod_g = 16'(tint.c.g) * 16'(tint.side.illumination);
		prod_b = 16'(tint.c.b) * 16'(tint.side.illumination);
		colour_d.frame_last = tint.side.frame_end;
		if (tint.side.water) begin
			colour_d.red   = thcs_pkg::WATER_R;
			colour_d.green = thcs_pkg::WATER_G;
			colour_d.blue  = thcs_pkg::WATER_B;
		end else begin
			colour_d.red   = prod_r[2*CW-1:CW];
			colour_d.green = prod_g[2*CW-1:CW];
			colour_d.blue  = prod_b[2*CW-1:CW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			colour <= colour_d;
		end
	end

endmodule

/* design/terrain_height_color_shader.sv */
// terrain_height_color_shader: top level, five stage pipe with stall chain
// depends on thcs_pkg, thcs_locate, thcs_blend and thcs_shade
`timescale 1ns / 1ps

// Takes one pixel word per cycle while pixel_stall is low and returns one
// colour word per pixel, in order. The stages are: ramp compare lanes,
// segment select, blend fraction, channel interpolation, and illumination
// scaling into the output register. Each stage moves on whenever the one
// after it is empty or moving, so bubbles close up and a word waiting at the
// output does not stop new pixels while the pipe has room; pixel_stall rises
// only when all five stages hold a word and the output is stalled, and
// follows colour_stall in the same cycle through that chain. Heights of zero
// or below give the fixed water colour; heights at or above the top ramp
// entry give the top colour, shaded. RAMP_ENTRIES (2 to 16) sets the number
// of ramp entries in use.

module terrain_height_color_shader #(
	parameter int RAMP_ENTRIES = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	output logic              pixel_stall,
	input  thcs_pkg::pixel_t  pixel,
	output logic              colour_valid,
	input  logic              colour_stall,
	output thcs_pkg::colour_t colour
);

	logic [1:0]      v_loc;
	logic [1:0]      v_bld;
	logic            v_out;
	logic [4:0]      en;
	thcs_pkg::seg_t  seg;
	thcs_pkg::tint_t tint;

	// stage enables, each stage moves when the next is empty or moving
	always_comb begin
		en[4] = !v_out || !colour_stall;
		en[3] = !v_bld[1] || en[4];
		en[2] = !v_bld[0] || en[3];
		en[1] = !v_loc[1] || en[2];
		en[0] = !v_loc[0] || en[1];
	end

	assign pixel_stall  = !en[0];
	assign colour_valid = v_out;

	thcs_locate #(
		.RAMP_ENTRIES(RAMP_ENTRIES)
	) u_locate (
		.clk    (clk),
		.arst_n (arst_n),
		.vin    (pixel_valid),
		.en     (en[1:0]),
		.pixel  (pixel),
		.v      (v_loc),
		.seg    (seg)
	);

	thcs_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.vin    (v_loc[1]),
		.en     (en[3:2]),
		.seg    (seg),
		.v      (v_bld),
		.tint   (tint)
	);

	thcs_shade u_shade (
		.clk    (clk),
		.arst_n (arst_n),
		.vin    (v_bld[1]),
		.en     (en[4]),
		.tint   (tint),
		.v      (v_out),
		.colour (colour)
	);

`ifndef SYNTH
	// an open output lets the whole pipe move
	a_open_output: assert property (@(posedge clk) disable iff (!arst_n)
		!colour_stall |-> !pixel_stall)
		else $error("input stalled while output is open");

	// the input stalls only with every stage full
	a_full_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> (v_loc == 2'b11) && (v_bld == 2'b11) && v_out)
		else $error("input stalled with a bubble in the pipe");

	// a pixel accepted while the output stays open reaches the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel_stall) ##1 !colour_stall ##1 !colour_stall
		##1 !colour_stall ##1 !colour_stall |=> colour_valid)
		else $error("pixel did not reach the output");
`endif

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for terrain_height_color_shader, random idling on both sides
// depends on thcs_pkg and the design files of the block
`timescale 1ns / 1ps

module tb_top;

	localparam int RAMP_N      = 12;
	localparam int CLK_HALF    = 5;
	localparam int STUCK_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 20;
	localparam int RAND_ITEMS  = 900;

	// ramp table: heights in metres and packed rgb per entry
	localparam int RAMP_H [16] = '{-1, 0, 250, 500, 750, 1000, 1250, 1500, 1750, 2000,
		2250, 2500, 2750, 3000, 3250, 3500};
	localparam logic [23:0] RAMP_RGB [16] = '{24'hffffff, 24'h70c0a7, 24'hcae7b9,
		24'hf4eaaf, 24'hdcb282, 24'hca8e72, 24'hdec8bd, 24'he3e4e9, 24'hdbd9ef,
		24'hcecdf5, 24'hc2c1fa, 24'hb7b9ff, 24'hb7b9ff, 24'hb7b9ff, 24'hb7b9ff,
		24'hb7b9ff};

	// expected colour words, predicted from accepted pixel words
	class colour_scoreboard;
		thcs_pkg::colour_t colour_due_q[$];
		int errors;
		int checked;
		int water_px;
		int ramp_px;
		int clamp_px;

		function int ramp_len();
			int n;
			n = RAMP_N;
			if (n < 2) n = 2;
			if (n > 16) n = 16;
			return n;
		endfunction

		function thcs_pkg::colour_t predict_colour(thcs_pkg::pixel_t p);
			thcs_pkg::colour_t c;
			int h, n, seg, span, f, k, lo, hi, illum;
			int rgb [3];
			h = $signed(p.height);
			n = ramp_len();
			illum = p.illumination;
			c.frame_last = p.frame_end;
			if (h <= 0) begin
				c.red   = 8'd64;
				c.green = 8'd96;
				c.blue  = 8'd240;
				return c;
			end
			if (h >= RAMP_H[n-1]) begin
				for (k = 0; k < 3; k++)
					rgb[k] = (RAMP_RGB[n-1] >> (16 - 8*k)) & 255;
			end else begin
				// highest entry at or below the height
				seg = 0;
				for (k = 0; k < n - 1; k++)
					if (h >= RAMP_H[k]) seg = k;
				span = RAMP_H[seg+1] - RAMP_H[seg];
				f = ((h - RAMP_H[seg]) * 255) / span;
				for (k = 0; k < 3; k++) begin
					lo = (RAMP_RGB[seg] >> (16 - 8*k)) & 255;
					hi = (RAMP_RGB[seg+1] >> (16 - 8*k)) & 255;
					rgb[k] = ((f * hi + (255 - f) * lo) >> 8) & 255;
				end
			end
			// shading by illumination
			c.red   = 8'(((rgb[0] * illum) >> 8) & 255);
			c.green = 8'(((rgb[1] * illum) >> 8) & 255);
			c.blue  = 8'(((rgb[2] * illum) >> 8) & 255);
			return c;
		endfunction

		function void note_pixel(thcs_pkg::pixel_t p);
			int h;
			h = $signed(p.height);
			if (h <= 0) water_px++;
			else if (h >= RAMP_H[ramp_len()-1]) clamp_px++;
			else ramp_px++;
			colour_due_q.push_back(predict_colour(p));
		endfunction

		function void check_colour(thcs_pkg::colour_t got);
			thcs_pkg::colour_t want;
			if (colour_due_q.size() == 0) begin
				$error("colour word with no pixel outstanding: %h", got);
				errors++;
				return;
			end
			want = colour_due_q.pop_front();
			checked++;
			if (got.red !== want.red) begin
				$error("red: expected %0d, got %0d", want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$error("green: expected %0d, got %0d", want.green, got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$error("blue: expected %0d, got %0d", want.blue, got.blue);
				errors++;
			end
			if (got.frame_last !== want.frame_last) begin
				$error("frame_last: expected %0d, got %0d", want.frame_last, got.frame_last);
				errors++;
			end
		endfunction

		function int pending();
			return colour_due_q.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              pixel_valid;
	logic              pixel_stall;
	thcs_pkg::pixel_t  pixel;
	logic              colour_valid;
	logic              colour_stall = 1'b0;
	thcs_pkg::colour_t colour;

	colour_scoreboard sb = new();
	bit quiet;
	int sent;
	int stall_left;
	int idle_cycles = 0;

	terrain_height_color_shader #(
		.RAMP_ENTRIES(RAMP_N)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.colour_valid(colour_valid),
		.colour_stall(colour_stall),
		.colour      (colour)
	);

	// clock
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap(int none_pct);
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < none_pct) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// send one pixel word, holding it until taken
	task automatic send_pixel(input thcs_pkg::pixel_t p);
		int gap;
		gap = pick_gap(60);
		@(negedge clk);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			pixel <= thcs_pkg::pixel_t'($urandom);
			repeat (gap) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (pixel_stall);
		sb.note_pixel(p);
		sent++;
	endtask

	// random pixel, weighted towards land inside the ramp
	function automatic thcs_pkg::pixel_t random_pixel();
		thcs_pkg::pixel_t p;
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			p.height = 16'($urandom_range(1, 2700));
		else if (r < 78)
			p.height = 16'(RAMP_H[$urandom_range(1, RAMP_N - 1)] + $urandom_range(0, 2) - 1);
		else if (r < 88)
			p.height = -16'($urandom_range(0, 32768));
		else
			p.height = 16'($urandom);
		r = $urandom_range(0, 9);
		if (r == 0) p.illumination = 8'd0;
		else if (r == 1) p.illumination = 8'd255;
		else p.illumination = 8'($urandom);
		p.frame_end = ($urandom_range(0, 15) == 0);
		return p;
	endfunction

	// output stall, bursts of random length
	always @(negedge clk) begin
		if (!arst_n || quiet) begin
			colour_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			colour_stall <= 1'b1;
			stall_left--;
		end else begin
			colour_stall <= 1'b0;
			stall_left = pick_gap(70);
		end
	end

	// output monitor and stuck-run watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (colour_valid && !colour_stall)
				sb.check_colour(colour);
			if ((pixel_valid && !pixel_stall) || (colour_valid && !colour_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STUCK_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int dir_h [24] = '{-32768, -1, 0, 1, 2, 124, 125, 249, 250, 251, 500, 750,
			1000, 1250, 1500, 1750, 2000, 2249, 2250, 2499, 2500, 2501, 32767, 16384};
		thcs_pkg::pixel_t p;
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		quiet = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: water, segment edges, clamp, illumination extremes
		for (int i = 0; i < 24; i++) begin
			p.height = 16'(dir_h[i]);
			p.illumination = (i % 3 == 0) ? 8'd255 : (i % 3 == 1) ? 8'd0 : 8'd128;
			p.frame_end = (i % 4 == 3);
			send_pixel(p);
		end
		p = '{height: 16'sh5555, illumination: 8'haa, frame_end: 1'b1};
		send_pixel(p);

		// random with idling, then a full drain
		for (int i = 0; i < RAND_ITEMS / 3; i++)
			send_pixel(random_pixel());
		@(negedge clk);
		pixel_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);

		// back to back with no stalls
		quiet = 1'b1;
		for (int i = 0; i < RAND_ITEMS / 4; i++)
			send_pixel(random_pixel());
		quiet = 1'b0;

		for (int i = 0; i < RAND_ITEMS - RAND_ITEMS / 3 - RAND_ITEMS / 4; i++)
			send_pixel(random_pixel());
		@(negedge clk);
		pixel_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d pixel words sent, %0d colour words compared", sent, sb.checked);
		$display("water %0d, interpolated %0d, clamped at top %0d",
			sb.water_px, sb.ramp_px, sb.clamp_px);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* terrain_height_color_shader.f */
design/thcs_pkg.sv
design/thcs_locate.sv
design/thcs_blend.sv
design/thcs_shade.sv
design/terrain_height_color_shader.sv
bench/tb_top.sv
